// ===== sv/hrhp_pkg.sv =====
package hrhp_pkg;

   // Status codes on the result channel
   localparam logic [1:0] ST_MORE = 2'd0;
   localparam logic [1:0] ST_LINE = 2'd1;
   localparam logic [1:0] ST_HEAD = 2'd2;
   localparam logic [1:0] ST_ERR  = 2'd3;

   // Method codes
   localparam logic [1:0] METHOD_NONE = 2'd0;
   localparam logic [1:0] METHOD_GET  = 2'd1;
   localparam logic [1:0] METHOD_POST = 2'd2;

   // Characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_DASH  = 8'h2d;

   localparam int RSP_DATA_W = 8;

   typedef struct packed {
      logic       uri_byte;
      logic [1:0] method;
      logic [1:0] status;
   } result_type;

endpackage

// ===== sv/hrhp_parse.sv =====
module hrhp_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         byte_in,
   output hrhp_pkg::result_type result
);
   import hrhp_pkg::*;

   typedef enum logic [3:0] {
      PH_START  = 4'd0,
      PH_METHOD = 4'd1,
      PH_URI    = 4'd2,
      PH_PROTO  = 4'd3,
      PH_MAJOR  = 4'd4,
      PH_MINOR  = 4'd5,
      PH_HSTART = 4'd6,
      PH_HNAME  = 4'd7,
      PH_HCOLON = 4'd8,
      PH_HSPACE = 4'd9,
      PH_HVALUE = 4'd10,
      PH_HEND   = 4'd11
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] len_ff, len_in;
   logic       get_ok_ff, get_ok_in;
   logic       post_ok_ff, post_ok_in;
   logic [1:0] code_ff, code_in;

   logic       is_upper, is_lower;
   logic [1:0] st;
   logic       uri;
   logic       get_hit, post_hit;

   function automatic logic [7:0] get_char(input logic [1:0] idx);
      unique case (idx)
         2'd0:    get_char = 8'h47; // G
         2'd1:    get_char = 8'h45; // E
         2'd2:    get_char = 8'h54; // T
         default: get_char = CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] post_char(input logic [2:0] idx);
      unique case (idx)
         3'd0:    post_char = 8'h50; // P
         3'd1:    post_char = 8'h4f; // O
         3'd2:    post_char = 8'h53; // S
         3'd3:    post_char = 8'h54; // T
         default: post_char = CH_SPACE;
      endcase
   endfunction

   assign is_upper = (byte_in >= 8'h41) && (byte_in <= 8'h5a);
   assign is_lower = (byte_in >= 8'h61) && (byte_in <= 8'h7a);
   assign get_hit  = (len_ff < 3'd4) && (get_char(len_ff[1:0]) == byte_in);
   assign post_hit = (len_ff < 3'd5) && (post_char(len_ff) == byte_in);

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      get_ok_in  = get_ok_ff;
      post_ok_in = post_ok_ff;
      code_in    = code_ff;
      st         = ST_MORE;
      uri        = 1'b0;

      unique case (phase_ff)
         PH_START: begin
            if (is_upper) begin
               get_ok_in  = get_ok_ff & get_hit;
               post_ok_in = post_ok_ff & post_hit;
               len_in     = len_ff + 3'd1;
               phase_in   = PH_METHOD;
            end else begin
               st = ST_ERR;
            end
         end
         PH_METHOD: begin
            priority if (is_upper || byte_in == CH_SPACE) begin
               get_ok_in  = get_ok_ff & get_hit;
               post_ok_in = post_ok_ff & post_hit;
               if (len_ff != 3'd7) len_in = len_ff + 3'd1;
            end else if (byte_in == CH_SLASH && len_ff == 3'd4 && get_ok_ff) begin
               code_in  = METHOD_GET;
               phase_in = PH_URI;
               uri      = 1'b1;
            end else if (byte_in == CH_SLASH && len_ff == 3'd5 && post_ok_ff) begin
               code_in  = METHOD_POST;
               phase_in = PH_URI;
               uri      = 1'b1;
            end else begin
               st = ST_ERR;
            end
         end
         PH_URI: begin
            if (byte_in == CH_SPACE) phase_in = PH_PROTO;
            else uri = 1'b1;
         end
         PH_PROTO: begin
            if (byte_in == CH_SLASH) phase_in = PH_MAJOR;
            else if (!is_upper) st = ST_ERR;
         end
         PH_MAJOR: begin
            if (byte_in == CH_DOT) phase_in = PH_MINOR;
         end
         PH_MINOR: begin
            if (byte_in == CH_LF) begin
               st       = ST_LINE;
               phase_in = PH_HSTART;
            end else if (byte_in != CH_ONE) begin
               st = ST_ERR;
            end
         end
         PH_HSTART: begin
            if (is_upper) phase_in = PH_HNAME;
            else st = ST_ERR;
         end
         PH_HNAME: begin
            if (byte_in == CH_COLON) phase_in = PH_HCOLON;
            else if (!(is_upper || is_lower || byte_in == CH_DASH)) st = ST_ERR;
         end
         PH_HCOLON: begin
            if (byte_in == CH_SPACE) phase_in = PH_HSPACE;
            else st = ST_ERR;
         end
         PH_HSPACE: begin
            if (is_upper || is_lower) phase_in = PH_HVALUE;
            else st = ST_ERR;
         end
         PH_HVALUE: begin
            if (byte_in == CH_LF) phase_in = PH_HEND;
         end
         PH_HEND: begin
            priority if (is_upper) phase_in = PH_HNAME;
            else if (byte_in == CH_LF) st = ST_HEAD;
            else st = ST_ERR;
         end
         default: st = ST_ERR;
      endcase

      result.status   = st;
      result.method   = code_in;
      result.uri_byte = uri;

      // head done or error: start over on a new request
      if (st == ST_ERR || st == ST_HEAD) begin
         phase_in   = PH_START;
         len_in     = 3'd0;
         get_ok_in  = 1'b1;
         post_ok_in = 1'b1;
         code_in    = METHOD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         len_ff     <= 3'd0;
         get_ok_ff  <= 1'b1;
         post_ok_ff <= 1'b1;
         code_ff    <= METHOD_NONE;
      end else if (step) begin
         phase_ff   <= phase_in;
         len_ff     <= len_in;
         get_ok_ff  <= get_ok_in;
         post_ok_ff <= post_ok_in;
         code_ff    <= code_in;
      end
   end

endmodule

// ===== sv/http_request_head_parser.sv =====
// HTTP request head parser.
// Input stream (req_*): one byte of the request head per beat in req_tdata.
// Result stream (rsp_*): one beat per input byte, in order, carrying
//   status (0 more, 1 request line done, 2 head done, 3 error), the method
//   recognized so far (0 none, 1 GET, 2 POST) and a flag for URI bytes.
// After head done or error the parser is back at the start of a request.
// Path: a byte accepted into the input register goes through the parse logic
//   into the result register, which drives rsp_tdata (two-register path: input
//   register, parse logic, result register).
// Throughput: one byte per clock while rsp_tready stays high; the parse state
//   is updated per byte; the next byte sees the state left by the previous one.
// Stall: when rsp_tready is low the result register holds; the input
//   register still takes one more byte, then req_tready drops until the
//   result drains. No beat is lost or repeated.
// Reset: synchronous, active high; both registers empty and the parser
//   returns to the start of a request line.
module http_request_head_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_in
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [hrhp_pkg::RSP_DATA_W-1:0] rsp_tdata // [1:0] status, [3:2] method,
                                                    // [4] uri_byte, [7:5] zero
);
   import hrhp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   result_type result;
   logic       advance;
   logic       req_take;

   // input register moves into the result register when that one is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   hrhp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .byte_in (in_byte_ff),
      .result  (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) in_byte_ff <= req_tdata;
      if (advance) out_data_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, out_data_ff};

endmodule

// ===== sv/hrhp_checker.sv =====
module hrhp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [hrhp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hrhp_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_method_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:2] != 2'd3 && rsp_tdata[7:5] == 3'd0)
      else $error("bad method code or pad bits");

   a_uri_ctx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[1:0] == ST_MORE
         && rsp_tdata[3:2] != METHOD_NONE)
      else $error("URI byte without method or with final status");

   // a waiting request beat stays put until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("waiting request beat changed");

endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import hrhp_pkg::*;

   localparam int RANDOM_BYTES = 450;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 20;     // idle clocks run after the last expected result beat
   localparam logic [31:0] GET_WORD  = "GET ";
   localparam logic [39:0] POST_WORD = "POST ";

   // parser position inside the request head, mirrored from the block
   typedef enum logic [3:0] {
      PH_START, PH_METHOD, PH_URI, PH_PROTO, PH_MAJOR, PH_MINOR,
      PH_HSTART, PH_HNAME, PH_HCOLON, PH_HSPACE, PH_HVALUE, PH_HEND
   } parse_phase_type;

   // one line of the directed stimulus table
   typedef struct {
      logic [7:0] b;
      bit         typed;   // want holds a hand-written result
      result_type want;
   } dir_row_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] byte_in
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata; // [1:0] status, [3:2] method, [4] uri_byte, [7:5] zero

   http_request_head_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // predicted parser state
   parse_phase_type phase;
   logic [2:0]   mlen;
   logic         get_ok;
   logic         post_ok;
   logic [1:0]   mcode;

   result_type  pending_results[$];   // expected result beats, oldest first
   dir_row_type dir_rows[$];
   logic [7:0]  req_bytes[$];          // bytes of the request being built
   bit          gapless;               // sender runs without idle cycles
   int          n_bytes, n_requests, n_results, n_line, n_head, n_err;
   int          errors;
   int          cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit is_upper(input logic [7:0] c);
      return c >= "A" && c <= "Z";
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return is_upper(c) || (c >= "a" && c <= "z");
   endfunction

   function automatic void restart_request();
      phase   = PH_START;
      mlen    = 3'd0;
      get_ok  = 1'b1;
      post_ok = 1'b1;
      mcode   = METHOD_NONE;
   endfunction

   // one more method character; the length sticks at 7, matching neither word
   function automatic void note_method_char(input logic [7:0] c);
      int m;
      m = mlen;
      if (m >= 4 || c != GET_WORD[8*(3-m) +: 8]) get_ok = 1'b0;
      if (m >= 5 || c != POST_WORD[8*(4-m) +: 8]) post_ok = 1'b0;
      if (m < 7) mlen = mlen + 3'd1;
   endfunction

   function automatic result_type parse_byte(input logic [7:0] c);
      result_type r;
      r.status   = ST_MORE;
      r.uri_byte = 1'b0;
      case (phase)
         PH_START: begin
            if (is_upper(c)) begin
               note_method_char(c);
               phase = PH_METHOD;
            end else r.status = ST_ERR;
         end
         PH_METHOD: begin
            if (is_upper(c) || c == CH_SPACE) begin
               note_method_char(c);
            end else if (c == CH_SLASH && mlen == 3'd4 && get_ok) begin
               mcode      = METHOD_GET;
               phase      = PH_URI;
               r.uri_byte = 1'b1;
            end else if (c == CH_SLASH && mlen == 3'd5 && post_ok) begin
               mcode      = METHOD_POST;
               phase      = PH_URI;
               r.uri_byte = 1'b1;
            end else r.status = ST_ERR;
         end
         PH_URI: begin
            if (c == CH_SPACE) phase = PH_PROTO;
            else r.uri_byte = 1'b1;
         end
         PH_PROTO: begin
            if (c == CH_SLASH) phase = PH_MAJOR;
            else if (!is_upper(c)) r.status = ST_ERR;
         end
         PH_MAJOR: begin
            if (c == CH_DOT) phase = PH_MINOR;
         end
         PH_MINOR: begin
            if (c == CH_LF) begin
               r.status = ST_LINE;
               phase    = PH_HSTART;
            end else if (c != CH_ONE) r.status = ST_ERR;
         end
         PH_HSTART: begin
            if (is_upper(c)) phase = PH_HNAME;
            else r.status = ST_ERR;
         end
         PH_HNAME: begin
            if (c == CH_COLON) phase = PH_HCOLON;
            else if (!(is_letter(c) || c == CH_DASH)) r.status = ST_ERR;
         end
         PH_HCOLON: begin
            if (c == CH_SPACE) phase = PH_HSPACE;
            else r.status = ST_ERR;
         end
         PH_HSPACE: begin
            if (is_letter(c)) phase = PH_HVALUE;
            else r.status = ST_ERR;
         end
         PH_HVALUE: begin
            if (c == CH_LF) phase = PH_HEND;
         end
         PH_HEND: begin
            if (is_upper(c)) phase = PH_HNAME;
            else if (c == CH_LF) r.status = ST_HEAD;
            else r.status = ST_ERR;
         end
         default: r.status = ST_ERR;
      endcase
      r.method = mcode;
      // error or a finished head drops the parser back to a fresh request
      if (r.status == ST_ERR || r.status == ST_HEAD) restart_request();
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // idle length: mostly none or short, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // uppercase letter with the range ends favored
   function automatic logic [7:0] rand_upper();
      case ($urandom_range(0, 7))
         0: return "A";
         1: return "Z";
         default: return 8'($urandom_range(65, 90));
      endcase
   endfunction

   function automatic logic [7:0] rand_letter();
      logic [7:0] c;
      c = rand_upper();
      return $urandom_range(0, 1) ? c : (c | 8'h20);
   endfunction

   function automatic logic [7:0] rand_not(input logic [7:0] x);
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      return (c == x) ? (x ^ 8'h01) : c;
   endfunction

   task automatic row(input logic [7:0] b);
      dir_row_type d;
      d.b     = b;
      d.typed = 1'b0;
      d.want  = '0;
      dir_rows.push_back(d);
   endtask

   task automatic row_typed(input logic [7:0] b, input logic [1:0] st, input logic [1:0] mth);
      dir_row_type d;
      d.b              = b;
      d.typed          = 1'b1;
      d.want.status    = st;
      d.want.method    = mth;
      d.want.uri_byte  = 1'b0;
      dir_rows.push_back(d);
   endtask

   // Builds one request head into req_bytes: mostly well formed with random
   // content, sometimes a bad method, no header lines, a flipped byte, a cut
   // short request, or plain noise.
   task automatic build_request();
      int n;
      req_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) req_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      n = $urandom_range(0, 9);
      if (n < 4) req_bytes = '{"G", "E", "T", CH_SPACE};
      else if (n < 8) req_bytes = '{"P", "O", "S", "T", CH_SPACE};
      else begin
         // random method word, long ones run the length counter into its limit
         repeat ($urandom_range(1, 9))
            req_bytes.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE : rand_upper());
      end
      req_bytes.push_back(CH_SLASH);
      repeat ($urandom_range(0, 6)) req_bytes.push_back(rand_not(CH_SPACE));
      req_bytes.push_back(CH_SPACE);
      repeat ($urandom_range(0, 4)) req_bytes.push_back(rand_upper());
      req_bytes.push_back(CH_SLASH);
      repeat ($urandom_range(0, 3)) req_bytes.push_back(rand_not(CH_DOT));
      req_bytes.push_back(CH_DOT);
      repeat ($urandom_range(0, 2)) req_bytes.push_back(CH_ONE);
      req_bytes.push_back(CH_LF);
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
      repeat (n) begin
         req_bytes.push_back(rand_upper());
         repeat ($urandom_range(0, 5))
            req_bytes.push_back(($urandom_range(0, 9) == 0) ? CH_DASH : rand_letter());
         req_bytes.push_back(CH_COLON);
         req_bytes.push_back(CH_SPACE);
         req_bytes.push_back(rand_letter());
         repeat ($urandom_range(0, 6)) req_bytes.push_back(rand_not(CH_LF));
         req_bytes.push_back(CH_LF);
      end
      req_bytes.push_back(CH_LF);
      if ($urandom_range(0, 4) == 0)
         req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, req_bytes.size() - 1);
         while (req_bytes.size() > n) void'(req_bytes.pop_back());
      end
   endtask

   // Offers one byte on the request channel; entered and left at a falling
   // edge. The expected result is queued at the edge that takes the beat.
   task automatic push_byte(input logic [7:0] b, input bit typed, input result_type want);
      int gap;
      result_type pred;
      gap = gapless ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = parse_byte(b);
      pending_results.push_back(typed ? want : pred);
      n_bytes++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin
      int sent;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      gapless    = 1'b0;
      restart_request();

      // directed table: byte extremes, a complete GET head, then rejects
      row_typed(8'h00, ST_ERR, METHOD_NONE);
      row_typed(8'hff, ST_ERR, METHOD_NONE);
      row("G"); row("E"); row("T"); row(CH_SPACE);
      row(CH_SLASH);                              // URI starts, method known
      row(CH_SPACE);                              // empty URI body
      row("A"); row(CH_SLASH);
      row(CH_DOT);                                // empty major version
      row_typed(CH_LF, ST_LINE, METHOD_GET);      // no minor digits at all
      row("Z"); row(CH_COLON); row(CH_SPACE); row("a");
      row(CH_LF);                                 // header line end reports more
      row_typed(CH_LF, ST_HEAD, METHOD_GET);
      row("A");
      row_typed(CH_SLASH, ST_ERR, METHOD_NONE);   // method too short
      row("Z");
      row_typed("z", ST_ERR, METHOD_NONE);        // lowercase inside method
      row_typed("@", ST_ERR, METHOD_NONE);        // just below 'A'
      row_typed("[", ST_ERR, METHOD_NONE);        // just above 'Z'

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) push_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         build_request();
         gapless = ($urandom_range(0, 3) == 0);
         foreach (req_bytes[i]) push_byte(req_bytes[i], 1'b0, '0);
         sent += req_bytes.size();
         n_requests++;
         // once in the run, hold the sender until the result side has drained
         if (n_requests == 6) begin
            req_tvalid = 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
      end
      req_tvalid = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d bytes (%0d random requests), %0d result beats checked",
               n_bytes, n_requests, n_results);
      $display("Status seen: %0d line done, %0d head done, %0d error; %0d mismatches",
               n_line, n_head, n_err, errors);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------- result side

   // ready toggles at falling edges: bursts of acceptance, then stalls
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_tready = 1'b1;
         repeat (($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8))
            @(negedge clock);
         if (idle_len() > 0) begin
            rsp_tready = 1'b0;
            repeat (idle_len() + 1) @(negedge clock);
         end
      end
   end

   task automatic log_error(input string msg);
      errors++;
      if (errors <= 10) $display("[%0t] %s", $realtime, msg);
   endtask

   // checker: every result beat against the oldest prediction; cycle limit
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[4:0]);
         n_results++;
         if (got.status == ST_LINE) n_line++;
         if (got.status == ST_HEAD) n_head++;
         if (got.status == ST_ERR)  n_err++;
         if (pending_results.size() == 0) begin
            log_error($sformatf("unexpected result beat, tdata %h", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.method !== want.method ||
                got.uri_byte !== want.uri_byte || rsp_tdata[7:5] !== 3'b000)
               log_error($sformatf(
                  {"beat %0d: want status %0d method %0d uri %0d, ",
                   "got status %0d method %0d uri %0d pad %b"},
                  n_results, want.status, want.method, want.uri_byte,
                  got.status, got.method, got.uri_byte, rsp_tdata[7:5]));
         end
      end
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
sv/hrhp_pkg.sv
sv/hrhp_parse.sv
sv/http_request_head_parser.sv
sv/hrhp_checker.sv
tb/testbench.sv
